// ===== design/mono_lcd_shadow_draw_engine_unit_macros.svh =====
// assertion macros for the lcd shadow draw engine
// used by the module that carries concurrent checks; no other dependencies
`ifndef MONO_LCD_SHADOW_DRAW_ENGINE_UNIT_MACROS_SVH
`define MONO_LCD_SHADOW_DRAW_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define MLSD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mlsd assertion failed");

// next-cycle implication, checked outside reset
`define MLSD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mlsd assertion failed");

`endif

// ===== design/mlsd_pkg.sv =====
// shared types and constants of the lcd shadow draw engine
// no dependencies
package mlsd_pkg;

  localparam int DEF_COLUMNS = 128;
  localparam int DEF_ROWS    = 64;

  typedef enum logic [2:0] {
    ACT_WR_BYTE = 3'd0,
    ACT_WR_DOT  = 3'd1,
    ACT_RD_BYTE = 3'd2,
    ACT_RD_DOT  = 3'd3,
    ACT_VLINE   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MOD
  } state_e;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // frame store port controls, address travels alongside
  typedef struct packed {
    logic       we;
    logic       re;
    logic [7:0] wdata;
  } mem_ctl_t;

endpackage

// ===== design/mlsd_fstore.sv =====
// single-port frame store, one byte per page and column, registered read data
// depends on mlsd_pkg for the port control struct
module mlsd_fstore #(
  parameter int DEPTH = mlsd_pkg::DEF_COLUMNS * ((mlsd_pkg::DEF_ROWS + 7) / 8),
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  mlsd_pkg::mem_ctl_t ctl_i,
  input  logic [AW-1:0]     addr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[addr_i] <= ctl_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

// ===== design/mlsd_engine.sv =====
// request sequencer: clearing sweep, read-modify-write per page, result register
// depends on mlsd_pkg and the assertion macro header
`include "mono_lcd_shadow_draw_engine_unit_macros.svh"

module mlsd_engine #(
  parameter int COLUMNS = mlsd_pkg::DEF_COLUMNS,
  parameter int ROWS    = mlsd_pkg::DEF_ROWS,
  parameter int DEPTH   = COLUMNS * ((ROWS + 7) / 8),
  parameter int AW      = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         action_i,
  input  logic [6:0]         column_i,
  input  logic [2:0]         page_i,
  input  logic [5:0]         row_i,
  input  logic [5:0]         row_end_i,
  input  logic [7:0]         value_i,
  output mlsd_pkg::mem_ctl_t mem_ctl_o,
  output logic [AW-1:0]      mem_addr_o,
  input  logic [7:0]         mem_rdata_i,
  output logic               strobe_o,
  output logic               kind_o,
  output logic [2:0]         out_page_o,
  output logic [6:0]         out_column_o,
  output logic [7:0]         data_o,
  output logic               last_o
);

  localparam int PAGES = (ROWS + 7) / 8;
  localparam logic [5:0] ROW_MAX = 6'(ROWS - 1);

  mlsd_pkg::state_e  state_q, state_d;
  mlsd_pkg::action_e act_q, act_d;
  logic [6:0]    col_q, col_d;
  logic [2:0]    pg_q, pg_d;
  logic [2:0]    bit_q, bit_d;
  logic [5:0]    y1_q, y1_d;
  logic [7:0]    val_q, val_d;
  logic [AW-1:0] clr_q, clr_d;

  logic       strobe_q, strobe_d;
  logic       kind_q, kind_d;
  logic [2:0] opg_q, opg_d;
  logic [6:0] ocol_q, ocol_d;
  logic [7:0] data_q, data_d;
  logic       last_q, last_d;

  logic       accept;
  logic       col_ok, pg_ok, row_ok;
  logic [5:0] y0c, y1c, lo, hi;
  logic       go_mem;
  logic       final_pg;
  logic       clr_done;
  logic [7:0] mask, new_byte;

  assign accept   = start && (state_q == mlsd_pkg::ST_IDLE);
  assign col_ok   = 32'(column_i) < COLUMNS;
  assign pg_ok    = 32'(page_i) < PAGES;
  assign row_ok   = 32'(row_i) < ROWS;
  assign y0c      = (32'(row_i) >= ROWS) ? ROW_MAX : row_i;
  assign y1c      = (32'(row_end_i) >= ROWS) ? ROW_MAX : row_end_i;
  assign lo       = (y0c > y1c) ? y1c : y0c;
  assign hi       = (y0c > y1c) ? y0c : y1c;
  assign final_pg = (pg_q == y1_q[5:3]);
  assign clr_done = (clr_q == AW'(DEPTH - 1));

  always_comb begin
    case (mlsd_pkg::action_e'(action_i))
      mlsd_pkg::ACT_WR_BYTE: go_mem = col_ok && pg_ok;
      mlsd_pkg::ACT_WR_DOT:  go_mem = col_ok && row_ok;
      mlsd_pkg::ACT_RD_BYTE: go_mem = col_ok && pg_ok;
      mlsd_pkg::ACT_RD_DOT:  go_mem = col_ok && row_ok;
      mlsd_pkg::ACT_VLINE:   go_mem = col_ok;
      default:               go_mem = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mlsd_pkg::ST_CLEAR: if (clr_done) state_d = mlsd_pkg::ST_IDLE;
      mlsd_pkg::ST_IDLE:  if (accept && go_mem) state_d = mlsd_pkg::ST_READ;
      mlsd_pkg::ST_READ:  state_d = mlsd_pkg::ST_MOD;
      mlsd_pkg::ST_MOD: begin
        if (act_q == mlsd_pkg::ACT_VLINE && !final_pg) begin
          state_d = mlsd_pkg::ST_READ;
        end else begin
          state_d = mlsd_pkg::ST_IDLE;
        end
      end
      default: state_d = mlsd_pkg::ST_IDLE;
    endcase
  end

  // byte update for the modify step
  always_comb begin
    mask = 8'h00;
    if (act_q == mlsd_pkg::ACT_WR_DOT) begin
      mask = 8'h01 << bit_q;
    end else begin
      mask = 8'hFF << bit_q;
      if (final_pg) begin
        mask = mask & (8'hFF >> (3'd7 - y1_q[2:0]));
      end
    end
    if (act_q == mlsd_pkg::ACT_WR_BYTE) begin
      new_byte = val_q;
    end else if (val_q[0]) begin
      new_byte = mem_rdata_i | mask;
    end else begin
      new_byte = mem_rdata_i & ~mask;
    end
  end

  // outputs and datapath
  always_comb begin
    act_d     = act_q;
    col_d     = col_q;
    pg_d      = pg_q;
    bit_d     = bit_q;
    y1_d      = y1_q;
    val_d     = val_q;
    clr_d     = clr_q;
    strobe_d  = 1'b0;
    kind_d    = kind_q;
    opg_d     = opg_q;
    ocol_d    = ocol_q;
    data_d    = data_q;
    last_d    = last_q;
    mem_ctl_o = '0;
    mem_addr_o = AW'(pg_q) * AW'(COLUMNS) + AW'(col_q);
    case (state_q)
      mlsd_pkg::ST_CLEAR: begin
        mem_ctl_o.we = 1'b1;
        mem_addr_o   = clr_q;
        clr_d        = clr_q + AW'(1);
      end
      mlsd_pkg::ST_IDLE: begin
        if (accept) begin
          act_d = mlsd_pkg::action_e'(action_i);
          col_d = column_i;
          val_d = value_i;
          y1_d  = hi;
          case (mlsd_pkg::action_e'(action_i))
            mlsd_pkg::ACT_WR_BYTE, mlsd_pkg::ACT_RD_BYTE: begin
              pg_d  = page_i;
              bit_d = 3'd0;
            end
            mlsd_pkg::ACT_VLINE: begin
              pg_d  = lo[5:3];
              bit_d = lo[2:0];
            end
            default: begin
              pg_d  = row_i[5:3];
              bit_d = row_i[2:0];
            end
          endcase
          // out-of-range reads answer zero without touching the store
          if (!go_mem && (action_i == mlsd_pkg::ACT_RD_BYTE ||
                          action_i == mlsd_pkg::ACT_RD_DOT)) begin
            strobe_d = 1'b1;
            kind_d   = mlsd_pkg::KIND_READ;
            opg_d    = (action_i == mlsd_pkg::ACT_RD_BYTE) ? page_i : row_i[5:3];
            ocol_d   = column_i;
            data_d   = 8'h00;
            last_d   = 1'b1;
          end
        end
      end
      mlsd_pkg::ST_READ: begin
        mem_ctl_o.re = 1'b1;
      end
      mlsd_pkg::ST_MOD: begin
        strobe_d = 1'b1;
        opg_d    = pg_q;
        ocol_d   = col_q;
        last_d   = 1'b1;
        if (act_q inside {mlsd_pkg::ACT_RD_BYTE, mlsd_pkg::ACT_RD_DOT}) begin
          kind_d = mlsd_pkg::KIND_READ;
          data_d = (act_q == mlsd_pkg::ACT_RD_BYTE) ? mem_rdata_i
                                                    : {7'd0, mem_rdata_i[bit_q]};
        end else begin
          kind_d          = mlsd_pkg::KIND_WRITE;
          data_d          = new_byte;
          mem_ctl_o.we    = 1'b1;
          mem_ctl_o.wdata = new_byte;
          if (act_q == mlsd_pkg::ACT_VLINE && !final_pg) begin
            last_d = 1'b0;
            pg_d   = pg_q + 3'd1;
            bit_d  = 3'd0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mlsd_pkg::ST_CLEAR;
      clr_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    col_q  <= col_d;
    pg_q   <= pg_d;
    bit_q  <= bit_d;
    y1_q   <= y1_d;
    val_q  <= val_d;
    kind_q <= kind_d;
    opg_q  <= opg_d;
    ocol_q <= ocol_d;
    data_q <= data_d;
    last_q <= last_d;
  end

  assign busy         = (state_q != mlsd_pkg::ST_IDLE);
  assign strobe_o     = strobe_q;
  assign kind_o       = kind_q;
  assign out_page_o   = opg_q;
  assign out_column_o = ocol_q;
  assign data_o       = data_q;
  assign last_o       = last_q;

  `MLSD_ASSERT_IMP(a_no_rd_wr_same_cycle, clk_i, rst_ni, mem_ctl_o.re, !mem_ctl_o.we)
  `MLSD_ASSERT_NXT(a_accept_goes_busy, clk_i, rst_ni, accept && go_mem, busy)
  `MLSD_ASSERT_NXT(a_strobe_source, clk_i, rst_ni,
                   !(state_q == mlsd_pkg::ST_MOD || state_q == mlsd_pkg::ST_IDLE), !strobe_q)
  `MLSD_ASSERT_IMP(a_line_continues, clk_i, rst_ni, strobe_q && !last_q,
                   state_q == mlsd_pkg::ST_READ && act_q == mlsd_pkg::ACT_VLINE)
  `MLSD_ASSERT_NXT(a_clear_runs_full, clk_i, rst_ni,
                   state_q == mlsd_pkg::ST_CLEAR && !clr_done, state_q == mlsd_pkg::ST_CLEAR)

endmodule

// ===== design/mono_lcd_shadow_draw_engine_unit.sv =====
// a result strobes once the request has passed the READ and MOD states and the
// result register; a vertical line emits one write per page it touches (up to 8)
// busy stays high through READ and MOD for each page, so no new request is taken until the item is done
// out-of-range reads answer on the next cycle; results cannot be stalled
// after reset the frame store is zeroed by a sweep over all COLUMNS*pages bytes
// (1024 by default) with busy held high
module mono_lcd_shadow_draw_engine_unit #(
  parameter int COLUMNS = mlsd_pkg::DEF_COLUMNS,
  parameter int ROWS    = mlsd_pkg::DEF_ROWS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] action_i,
  input  logic [6:0] column_i,
  input  logic [2:0] page_i,
  input  logic [5:0] row_i,
  input  logic [5:0] row_end_i,
  input  logic [7:0] value_i,
  output logic       strobe_o,
  output logic       kind_o,
  output logic [2:0] out_page_o,
  output logic [6:0] out_column_o,
  output logic [7:0] data_o,
  output logic       last_o
);

  localparam int DEPTH = COLUMNS * ((ROWS + 7) / 8);
  localparam int AW    = $clog2(DEPTH);

  mlsd_pkg::mem_ctl_t mem_ctl;
  logic [AW-1:0]      mem_addr;
  logic [7:0]         mem_rdata;

  mlsd_engine #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .DEPTH   (DEPTH),
    .AW      (AW)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .action_i     (action_i),
    .column_i     (column_i),
    .page_i       (page_i),
    .row_i        (row_i),
    .row_end_i    (row_end_i),
    .value_i      (value_i),
    .mem_ctl_o    (mem_ctl),
    .mem_addr_o   (mem_addr),
    .mem_rdata_i  (mem_rdata),
    .strobe_o     (strobe_o),
    .kind_o       (kind_o),
    .out_page_o   (out_page_o),
    .out_column_o (out_column_o),
    .data_o       (data_o),
    .last_o       (last_o)
  );

  mlsd_fstore #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_fstore (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .addr_i  (mem_addr),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== bench/tb_mono_lcd_shadow_draw_engine_unit.sv =====
// testbench for the lcd shadow draw engine: a directed table, then random drawing requests
// each beat is checked against the table's expected beat or a shadow frame store model kept here; needs mlsd_pkg
`timescale 1ns / 100ps

module tb_mono_lcd_shadow_draw_engine_unit;

  localparam int N_PAGES = 8;
  localparam int N_COLS = 128;
  localparam int RANDOM_REQS = 300;
  localparam int TAIL_CYCLES = 20;
  localparam int CYCLE_LIMIT = 200000;
  // actions 5..7 are not decoded by the block
  localparam logic [2:0] ACT_FIRST_UNUSED = 3'd5;

  typedef struct packed {
    logic [2:0] action;
    logic [6:0] column;
    logic [2:0] page;
    logic [5:0] row;
    logic [5:0] row_end;
    logic [7:0] value;
  } draw_req_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] page;
    logic [6:0] column;
    logic [7:0] data;
    logic       last;
  } lcd_beat_t;

  typedef struct packed {
    draw_req_t req;
    logic      typed;
    lcd_beat_t want;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] action_i = '0;
  logic [6:0] column_i = '0;
  logic [2:0] page_i = '0;
  logic [5:0] row_i = '0;
  logic [5:0] row_end_i = '0;
  logic [7:0] value_i = '0;
  logic       strobe_o;
  logic       kind_o;
  logic [2:0] out_page_o;
  logic [6:0] out_column_o;
  logic [7:0] data_o;
  logic       last_o;

  logic [7:0] shadow_frame [N_PAGES][N_COLS];
  lcd_beat_t  draw_beats [8];
  int         draw_beat_cnt;
  lcd_beat_t  pending_beats [$];
  stim_row_t  stim_table [$];

  int err_cnt = 0;
  int cycle_cnt = 0;
  int accepted_cnt = 0;
  int ignored_cnt = 0;
  int writes_seen = 0;
  int reads_seen = 0;

  mono_lcd_shadow_draw_engine_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .action_i    (action_i),
    .column_i    (column_i),
    .page_i      (page_i),
    .row_i       (row_i),
    .row_end_i   (row_end_i),
    .value_i     (value_i),
    .strobe_o    (strobe_o),
    .kind_o      (kind_o),
    .out_page_o  (out_page_o),
    .out_column_o(out_column_o),
    .data_o      (data_o),
    .last_o      (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d beats still pending", $time, pending_beats.size());
      $display("tb_mono_lcd_shadow_draw_engine_unit: done, errors");
      $finish;
    end
  end

  task automatic add_beat(input logic kind, input int pg, input int col, input logic [7:0] dat);
    draw_beats[draw_beat_cnt] = '{kind: kind, page: pg[2:0], column: col[6:0], data: dat,
                                  last: 1'b0};
    draw_beat_cnt++;
  endtask

  // shadow frame update and the beats one request produces
  task automatic predict_draw(input draw_req_t r);
    logic [7:0] b;
    logic [7:0] m;
    int         y0;
    int         y1;
    int         t;
    int         p;
    bit         fin;
    draw_beat_cnt = 0;
    case (r.action)
      mlsd_pkg::ACT_WR_BYTE: begin
        shadow_frame[r.page][r.column] = r.value;
        add_beat(mlsd_pkg::KIND_WRITE, int'(r.page), int'(r.column), r.value);
      end
      mlsd_pkg::ACT_WR_DOT: begin
        p = int'(r.row[5:3]);
        b = shadow_frame[p][r.column];
        b[r.row[2:0]] = r.value[0];
        shadow_frame[p][r.column] = b;
        add_beat(mlsd_pkg::KIND_WRITE, p, int'(r.column), b);
      end
      mlsd_pkg::ACT_RD_BYTE: begin
        add_beat(mlsd_pkg::KIND_READ, int'(r.page), int'(r.column),
                 shadow_frame[r.page][r.column]);
      end
      mlsd_pkg::ACT_RD_DOT: begin
        b = shadow_frame[r.row[5:3]][r.column];
        add_beat(mlsd_pkg::KIND_READ, int'(r.row[5:3]), int'(r.column),
                 {7'd0, b[r.row[2:0]]});
      end
      mlsd_pkg::ACT_VLINE: begin
        y0 = int'(r.row);
        y1 = int'(r.row_end);
        if (y0 > y1) begin
          t = y0;
          y0 = y1;
          y1 = t;
        end
        // one read-modify-write per page, masks trimmed at both ends
        do begin
          p = y0 >> 3;
          b = shadow_frame[p][r.column];
          m = 8'hFF << (y0 & 7);
          fin = (p == (y1 >> 3));
          if (fin) m = m & (8'hFF >> (7 - (y1 & 7)));
          b = r.value[0] ? (b | m) : (b & ~m);
          shadow_frame[p][r.column] = b;
          add_beat(mlsd_pkg::KIND_WRITE, p, int'(r.column), b);
          y0 = (y0 & ~7) + 8;
        end while (!fin);
      end
      default: ;
    endcase
    if (draw_beat_cnt > 0) draw_beats[draw_beat_cnt - 1].last = 1'b1;
  endtask

  task automatic tab(input logic [2:0] act, input int col, input int pg, input int row,
                     input int row_end, input int val, input bit typed, input logic kind,
                     input int opg, input int ocol, input int odata);
    stim_row_t s;
    s.req = '{action: act, column: col[6:0], page: pg[2:0], row: row[5:0],
              row_end: row_end[5:0], value: val[7:0]};
    s.typed = typed;
    s.want = '{kind: kind, page: opg[2:0], column: ocol[6:0], data: odata[7:0], last: 1'b1};
    stim_table.push_back(s);
  endtask

  // start stays high until the edge that takes the request
  task automatic issue_request(input draw_req_t r, input bit typed, input lcd_beat_t want);
    int i;
    start <= 1'b1;
    action_i <= r.action;
    column_i <= r.column;
    page_i <= r.page;
    row_i <= r.row;
    row_end_i <= r.row_end;
    value_i <= r.value;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    accepted_cnt++;
    predict_draw(r);
    if (draw_beat_cnt == 0) ignored_cnt++;
    if (typed) pending_beats.push_back(want);
    else for (i = 0; i < draw_beat_cnt; i++) pending_beats.push_back(draw_beats[i]);
  endtask

  task automatic sender_pause(input int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  function automatic draw_req_t random_request();
    draw_req_t r;
    int        pick;
    r.value = 8'($urandom);
    r.page = 3'($urandom);
    r.row = 6'($urandom);
    r.row_end = 6'($urandom);
    pick = $urandom_range(99);
    if (pick < 20) r.action = mlsd_pkg::ACT_WR_BYTE;
    else if (pick < 40) r.action = mlsd_pkg::ACT_WR_DOT;
    else if (pick < 55) r.action = mlsd_pkg::ACT_RD_BYTE;
    else if (pick < 70) r.action = mlsd_pkg::ACT_RD_DOT;
    else if (pick < 90) r.action = mlsd_pkg::ACT_VLINE;
    else r.action = 3'(ACT_FIRST_UNUSED + $urandom_range(2));
    // a few hot columns so reads land on drawn bytes
    pick = $urandom_range(9);
    if (pick < 5) r.column = 7'($urandom_range(3));
    else if (pick == 5) r.column = 7'd127;
    else if (pick == 6) r.column = 7'd0;
    else r.column = 7'($urandom);
    // short lines inside one page now and then
    if ($urandom_range(3) == 0) r.row_end = r.row ^ 6'($urandom_range(7));
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : result_mon
    lcd_beat_t want;
    if (rst_ni && strobe_o) begin
      if (kind_o == mlsd_pkg::KIND_READ) reads_seen++;
      else writes_seen++;
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual kind %0d page %0d col %0d data 0x%0h",
                 $time, kind_o, out_page_o, out_column_o, data_o);
        err_cnt++;
      end else begin
        want = pending_beats.pop_front();
        check_field("kind", int'(want.kind), int'(kind_o));
        check_field("page", int'(want.page), int'(out_page_o));
        check_field("column", int'(want.column), int'(out_column_o));
        check_field("data", int'(want.data), int'(data_o));
        check_field("last", int'(want.last), int'(last_o));
      end
    end
  end

  initial begin : stim
    draw_req_t r;
    int        i;
    int        defined_cnt;
    int        idle_pct;
    defined_cnt = 0;
    foreach (shadow_frame[p, c]) shadow_frame[p][c] = 8'h00;

    // store reads zero after the clearing sweep
    tab(mlsd_pkg::ACT_RD_BYTE, 0, 0, 0, 0, 8'h00, 1, mlsd_pkg::KIND_READ, 0, 0, 8'h00);
    tab(mlsd_pkg::ACT_RD_BYTE, 127, 7, 0, 0, 8'h00, 1, mlsd_pkg::KIND_READ, 7, 127, 8'h00);
    tab(mlsd_pkg::ACT_RD_DOT, 127, 0, 63, 0, 8'h00, 1, mlsd_pkg::KIND_READ, 7, 127, 8'h00);
    tab(mlsd_pkg::ACT_WR_BYTE, 0, 0, 0, 0, 8'hFF, 1, mlsd_pkg::KIND_WRITE, 0, 0, 8'hFF);
    tab(mlsd_pkg::ACT_WR_BYTE, 127, 7, 0, 0, 8'h00, 1, mlsd_pkg::KIND_WRITE, 7, 127, 8'h00);
    tab(mlsd_pkg::ACT_RD_BYTE, 0, 0, 0, 0, 8'h00, 1, mlsd_pkg::KIND_READ, 0, 0, 8'hFF);
    tab(mlsd_pkg::ACT_WR_DOT, 127, 0, 63, 0, 8'h01, 1, mlsd_pkg::KIND_WRITE, 7, 127, 8'h80);
    // clear mode with the upper value bits set
    tab(mlsd_pkg::ACT_WR_DOT, 0, 0, 7, 0, 8'hFE, 1, mlsd_pkg::KIND_WRITE, 0, 0, 8'h7F);
    // dot read uses row / 8 as the page
    tab(mlsd_pkg::ACT_RD_DOT, 0, 0, 7, 0, 8'h00, 1, mlsd_pkg::KIND_READ, 0, 0, 8'h00);
    tab(mlsd_pkg::ACT_RD_DOT, 0, 0, 0, 0, 8'h00, 1, mlsd_pkg::KIND_READ, 0, 0, 8'h01);
    tab(mlsd_pkg::ACT_WR_DOT, 64, 5, 32, 0, 8'h01, 0, mlsd_pkg::KIND_WRITE, 0, 0, 0);
    tab(mlsd_pkg::ACT_VLINE, 5, 0, 0, 63, 8'h01, 0, mlsd_pkg::KIND_WRITE, 0, 0, 0);
    // reversed ends, clear
    tab(mlsd_pkg::ACT_VLINE, 5, 0, 60, 3, 8'h00, 0, mlsd_pkg::KIND_WRITE, 0, 0, 0);
    tab(mlsd_pkg::ACT_VLINE, 127, 0, 10, 10, 8'h01, 0, mlsd_pkg::KIND_WRITE, 0, 0, 0);
    tab(mlsd_pkg::ACT_VLINE, 0, 0, 17, 22, 8'hFF, 0, mlsd_pkg::KIND_WRITE, 0, 0, 0);
    tab(mlsd_pkg::ACT_VLINE, 0, 0, 63, 0, 8'hFE, 0, mlsd_pkg::KIND_WRITE, 0, 0, 0);
    tab(mlsd_pkg::ACT_RD_BYTE, 5, 0, 0, 0, 8'h00, 0, mlsd_pkg::KIND_READ, 0, 0, 0);
    tab(mlsd_pkg::ACT_RD_DOT, 5, 0, 61, 0, 8'h00, 0, mlsd_pkg::KIND_READ, 0, 0, 0);
    // undecoded actions give nothing
    tab(ACT_FIRST_UNUSED, 127, 7, 63, 63, 8'hFF, 0, mlsd_pkg::KIND_WRITE, 0, 0, 0);
    tab(ACT_FIRST_UNUSED + 3'd1, 1, 3, 20, 40, 8'h01, 0, mlsd_pkg::KIND_WRITE, 0, 0, 0);
    tab(ACT_FIRST_UNUSED + 3'd2, 0, 0, 0, 0, 8'h00, 0, mlsd_pkg::KIND_WRITE, 0, 0, 0);
    tab(mlsd_pkg::ACT_WR_BYTE, 3, 4, 0, 0, 8'h5A, 1, mlsd_pkg::KIND_WRITE, 4, 3, 8'h5A);
    tab(mlsd_pkg::ACT_RD_BYTE, 3, 4, 0, 0, 8'h00, 1, mlsd_pkg::KIND_READ, 4, 3, 8'h5A);
    tab(mlsd_pkg::ACT_VLINE, 3, 0, 32, 39, 8'h01, 0, mlsd_pkg::KIND_WRITE, 0, 0, 0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < stim_table.size(); i++) begin
      sender_pause(29);
      issue_request(stim_table[i].req, stim_table[i].typed, stim_table[i].want);
    end

    while (defined_cnt < RANDOM_REQS) begin
      idle_pct = (defined_cnt < RANDOM_REQS / 3) ? 29 :
                 (defined_cnt < 2 * RANDOM_REQS / 3) ? 50 : 0;
      sender_pause(idle_pct);
      r = random_request();
      issue_request(r, 1'b0, '0);
      if (r.action < ACT_FIRST_UNUSED) defined_cnt++;
    end
    start <= 1'b0;

    while (pending_beats.size() != 0 || busy) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d requests taken, %0d of them gave no beat", accepted_cnt, ignored_cnt);
    $display("%0d display writes and %0d read answers compared", writes_seen, reads_seen);
    if (err_cnt == 0) begin
      $display("tb_mono_lcd_shadow_draw_engine_unit: done, clean");
    end else begin
      $display("tb_mono_lcd_shadow_draw_engine_unit: done, errors");
    end
    $finish;
  end

endmodule
